@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker of the ancestor query block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TLA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TLA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tla_pkg.sv @@
// Shared field widths, command codes and sequencer states of the ancestor query block.
package tla_pkg;

    localparam int IN_W = 10;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [IN_W-1:0] OUT_NONE = '1;

    typedef enum logic [18:0] {
        ST_IDLE    = 19'b000_0000_0000_0000_0001,
        ST_RED     = 19'b000_0000_0000_0000_0010,
        ST_L_DEP   = 19'b000_0000_0000_0000_0100,
        ST_L_WR0   = 19'b000_0000_0000_0000_1000,
        ST_L_RD    = 19'b000_0000_0000_0001_0000,
        ST_L_WR    = 19'b000_0000_0000_0010_0000,
        ST_Q_RDA   = 19'b000_0000_0000_0100_0000,
        ST_Q_RDB   = 19'b000_0000_0000_1000_0000,
        ST_Q_CMP   = 19'b000_0000_0001_0000_0000,
        ST_Q_LIFT  = 19'b000_0000_0010_0000_0000,
        ST_Q_LIFTA = 19'b000_0000_0100_0000_0000,
        ST_Q_LIFTD = 19'b000_0000_1000_0000_0000,
        ST_Q_EQ    = 19'b000_0001_0000_0000_0000,
        ST_Q_JA    = 19'b000_0010_0000_0000_0000,
        ST_Q_JB    = 19'b000_0100_0000_0000_0000,
        ST_Q_JC    = 19'b000_1000_0000_0000_0000,
        ST_Q_TOP   = 19'b001_0000_0000_0000_0000,
        ST_Q_TOPD  = 19'b010_0000_0000_0000_0000,
        ST_Q_OUT   = 19'b100_0000_0000_0000_0000
    } state_t;

endpackage

@@ rtl/tree_lca_binary_lifting_core.sv @@
// Top level of the binary-lifting ancestor table and lowest-common-ancestor query engine.
//
// Input channel (in_valid / in_stall): one request per handshake. cmd selects a load
// (node, parent, has_parent) or a query (query_a, query_b). Parents are loaded first.
// Output channel (out_valid / out_stall): one ancestor per query, none per load.
// One request is worked at a time; in_stall is low only while the sequencer is idle.
// Node indexes are first reduced modulo NODES in ST_RED, one compare-subtract per cycle;
// the reduction is skipped when NODES >= 1024.
// A load writes the depth and level 0, then walks the chain of dependent reads of the ancestor
// RAM (one registered read port) level by level; levels above a root need no read.
// A query reads and orders the depths, lifts the deeper node to equal depth, checks
// equality, runs the joint lift and final read unless the nodes already match, and
// passes the answer to the output register.
// A finished result waits in the output register while out_stall is high; the next
// request is taken meanwhile, and a later query holds in its last state until the
// register is free.
// Reset clears the sequencer and the output valid; the RAM contents are undefined
// until written, so a query must name only nodes already loaded.
module tree_lca_binary_lifting_core
    import tla_pkg::*;
#(
    parameter int NODES  = 1024,
    parameter int LEVELS = 10
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            cmd,
    input  logic [IN_W-1:0] node,
    input  logic [IN_W-1:0] parent,
    input  logic            has_parent,
    input  logic [IN_W-1:0] query_a,
    input  logic [IN_W-1:0] query_b,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [IN_W-1:0] ancestor
);

    localparam int NW        = $clog2(NODES);
    localparam int EW        = NW + 1;
    localparam int LVW       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int AAW       = $clog2(NODES * LEVELS);
    localparam int SW        = ((NW > LEVELS) ? NW : LEVELS) + 1;
    localparam int RCW       = 4;
    localparam int RED_SW    = IN_W + 16;
    localparam int RED_STEPS = (NODES < (1 << IN_W)) ?
                               $clog2(((1 << IN_W) + NODES - 1) / NODES) : 0;

    localparam logic [RED_SW-1:0] RED_BASE  = RED_SW'(NODES);
    localparam logic [EW-1:0]     ANC_NONE  = '1;
    localparam logic [NW-1:0]     DEPTH_MAX = NW'(NODES - 1);
    localparam logic [LVW-1:0]    LVL_TOP   = LVW'(LEVELS - 1);
    localparam logic [RCW-1:0]    RED_FIRST = RCW'(RED_STEPS - 1);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    logic [IN_W-1:0] ancestor_reg, ancestor_next;
    logic            hp_reg, hp_next;
    logic [IN_W-1:0] x_reg, x_next;
    logic [IN_W-1:0] y_reg, y_next;
    logic [RCW-1:0]  red_cnt_reg, red_cnt_next;
    logic [LVW-1:0]  lvl_reg, lvl_next;
    logic [NW-1:0]   a_reg, a_next;
    logic [NW-1:0]   b_reg, b_next;
    logic [NW-1:0]   da_reg, da_next;
    logic [NW-1:0]   db_reg, db_next;
    logic [EW-1:0]   prev_reg, prev_next;
    logic [EW-1:0]   ua_reg, ua_next;
    logic [IN_W-1:0] res_reg, res_next;
    logic            cmd_reg, cmd_next;

    logic [NW-1:0]  x_idx, y_idx;
    logic [RED_SW-1:0] red_sub, x_ext, y_ext;
    logic [IN_W-1:0] x_red, y_red;
    logic [SW-1:0]  lift_step;
    logic           lift_ok;
    logic           out_free;
    logic [NW:0]    dep_inc;
    logic [NW-1:0]  dep_new;
    logic           lvl_zero, lvl_end;

    logic           dep_wr_en, dep_rd_en;
    logic [NW-1:0]  dep_wr_addr, dep_wr_data, dep_rd_addr, dep_rd_data;

    logic           anc_wr_en, anc_rd_en;
    logic [NW-1:0]  anc_wr_node, anc_rd_node;
    logic [LVW-1:0] anc_wr_lvl, anc_rd_lvl;
    logic [AAW-1:0] anc_wr_addr, anc_rd_addr;
    logic [EW-1:0]  anc_wr_data, anc_rd_data;

    assign x_idx = NW'(x_reg);
    assign y_idx = NW'(y_reg);

    assign red_sub = RED_BASE << red_cnt_reg;
    assign x_ext   = RED_SW'(x_reg);
    assign y_ext   = RED_SW'(y_reg);
    assign x_red   = (x_ext >= red_sub) ? IN_W'(x_ext - red_sub) : x_reg;
    assign y_red   = (y_ext >= red_sub) ? IN_W'(y_ext - red_sub) : y_reg;

    assign lift_step = SW'(1) << lvl_reg;
    assign lift_ok   = SW'(da_reg) >= (SW'(db_reg) + lift_step);

    assign dep_inc = {1'b0, dep_rd_data} + (NW + 1)'(1);
    assign dep_new = (dep_rd_data >= DEPTH_MAX) ? DEPTH_MAX : dep_inc[NW-1:0];

    assign lvl_zero = (lvl_reg == '0);
    assign lvl_end  = (lvl_reg == LVL_TOP);
    assign out_free = !out_valid_reg || !out_stall;

    assign anc_wr_addr = AAW'(anc_wr_node) * AAW'(LEVELS) + AAW'(anc_wr_lvl);
    assign anc_rd_addr = AAW'(anc_rd_node) * AAW'(LEVELS) + AAW'(anc_rd_lvl);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        ancestor_next  = ancestor_reg;
        cmd_next       = cmd_reg;
        hp_next        = hp_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        red_cnt_next   = red_cnt_reg;
        lvl_next       = lvl_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        da_next        = da_reg;
        db_next        = db_reg;
        prev_next      = prev_reg;
        ua_next        = ua_reg;
        res_next       = res_reg;

        dep_wr_en   = 1'b0;
        dep_wr_addr = x_idx;
        dep_wr_data = dep_new;
        dep_rd_en   = 1'b0;
        dep_rd_addr = y_idx;
        anc_wr_en   = 1'b0;
        anc_wr_node = x_idx;
        anc_wr_lvl  = lvl_reg;
        anc_wr_data = anc_rd_data;
        anc_rd_en   = 1'b0;
        anc_rd_node = a_reg;
        anc_rd_lvl  = lvl_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next     = cmd;
                    hp_next      = has_parent;
                    x_next       = (cmd == CMD_QUERY) ? query_a : node;
                    y_next       = (cmd == CMD_QUERY) ? query_b : parent;
                    red_cnt_next = RED_FIRST;
                    if (RED_STEPS > 0)
                    begin
                        state_next = ST_RED;
                    end
                    else if (cmd == CMD_QUERY)
                    begin
                        state_next = ST_Q_RDA;
                    end
                    else
                    begin
                        state_next = ST_L_DEP;
                    end
                end
            end
            ST_RED:
            begin
                x_next       = x_red;
                y_next       = y_red;
                red_cnt_next = red_cnt_reg - RCW'(1);
                if (red_cnt_reg == '0)
                begin
                    state_next = (cmd_reg == CMD_QUERY) ? ST_Q_RDA : ST_L_DEP;
                end
            end
            ST_L_DEP:
            begin
                dep_rd_en   = 1'b1;
                dep_rd_addr = y_idx;
                state_next  = ST_L_WR0;
            end
            ST_L_WR0:
            begin
                dep_wr_en   = 1'b1;
                dep_wr_data = hp_reg ? dep_new : '0;
                anc_wr_en   = 1'b1;
                anc_wr_lvl  = '0;
                anc_wr_data = hp_reg ? {1'b0, y_idx} : ANC_NONE;
                prev_next   = hp_reg ? {1'b0, y_idx} : ANC_NONE;
                lvl_next    = LVW'(1);
                state_next  = (LEVELS > 1) ? ST_L_RD : ST_IDLE;
            end
            ST_L_RD:
            begin
                if (prev_reg == ANC_NONE)
                begin
                    anc_wr_en   = 1'b1;
                    anc_wr_data = ANC_NONE;
                    lvl_next    = lvl_reg + LVW'(1);
                    state_next  = lvl_end ? ST_IDLE : ST_L_RD;
                end
                else
                begin
                    anc_rd_en   = 1'b1;
                    anc_rd_node = prev_reg[NW-1:0];
                    anc_rd_lvl  = lvl_reg - LVW'(1);
                    state_next  = ST_L_WR;
                end
            end
            ST_L_WR:
            begin
                anc_wr_en   = 1'b1;
                anc_wr_data = anc_rd_data;
                prev_next   = anc_rd_data;
                lvl_next    = lvl_reg + LVW'(1);
                state_next  = lvl_end ? ST_IDLE : ST_L_RD;
            end
            ST_Q_RDA:
            begin
                dep_rd_en   = 1'b1;
                dep_rd_addr = x_idx;
                a_next      = x_idx;
                b_next      = y_idx;
                state_next  = ST_Q_RDB;
            end
            ST_Q_RDB:
            begin
                da_next     = dep_rd_data;
                dep_rd_en   = 1'b1;
                dep_rd_addr = b_reg;
                state_next  = ST_Q_CMP;
            end
            ST_Q_CMP:
            begin
                if (da_reg < dep_rd_data)
                begin
                    a_next  = b_reg;
                    b_next  = a_reg;
                    da_next = dep_rd_data;
                    db_next = da_reg;
                end
                else
                begin
                    db_next = dep_rd_data;
                end
                lvl_next   = LVL_TOP;
                state_next = ST_Q_LIFT;
            end
            ST_Q_LIFT:
            begin
                if (lift_ok)
                begin
                    anc_rd_en  = 1'b1;
                    state_next = ST_Q_LIFTA;
                end
                else
                begin
                    lvl_next   = lvl_reg - LVW'(1);
                    state_next = lvl_zero ? ST_Q_EQ : ST_Q_LIFT;
                end
            end
            ST_Q_LIFTA:
            begin
                if (anc_rd_data != ANC_NONE)
                begin
                    a_next      = anc_rd_data[NW-1:0];
                    dep_rd_en   = 1'b1;
                    dep_rd_addr = anc_rd_data[NW-1:0];
                    state_next  = ST_Q_LIFTD;
                end
                else
                begin
                    lvl_next   = lvl_reg - LVW'(1);
                    state_next = lvl_zero ? ST_Q_EQ : ST_Q_LIFT;
                end
            end
            ST_Q_LIFTD:
            begin
                da_next    = dep_rd_data;
                lvl_next   = lvl_reg - LVW'(1);
                state_next = lvl_zero ? ST_Q_EQ : ST_Q_LIFT;
            end
            ST_Q_EQ:
            begin
                if (a_reg == b_reg)
                begin
                    res_next   = IN_W'(a_reg);
                    state_next = ST_Q_OUT;
                end
                else
                begin
                    lvl_next   = LVL_TOP;
                    state_next = ST_Q_JA;
                end
            end
            ST_Q_JA:
            begin
                anc_rd_en   = 1'b1;
                anc_rd_node = a_reg;
                state_next  = ST_Q_JB;
            end
            ST_Q_JB:
            begin
                ua_next     = anc_rd_data;
                anc_rd_en   = 1'b1;
                anc_rd_node = b_reg;
                state_next  = ST_Q_JC;
            end
            ST_Q_JC:
            begin
                if ((ua_reg != anc_rd_data) && (ua_reg != ANC_NONE) &&
                    (anc_rd_data != ANC_NONE))
                begin
                    a_next = ua_reg[NW-1:0];
                    b_next = anc_rd_data[NW-1:0];
                end
                lvl_next   = lvl_reg - LVW'(1);
                state_next = lvl_zero ? ST_Q_TOP : ST_Q_JA;
            end
            ST_Q_TOP:
            begin
                anc_rd_en   = 1'b1;
                anc_rd_node = a_reg;
                anc_rd_lvl  = '0;
                state_next  = ST_Q_TOPD;
            end
            ST_Q_TOPD:
            begin
                res_next   = (anc_rd_data == ANC_NONE) ? OUT_NONE :
                             IN_W'(anc_rd_data[NW-1:0]);
                state_next = ST_Q_OUT;
            end
            ST_Q_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    ancestor_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ancestor_reg <= ancestor_next;
        cmd_reg      <= cmd_next;
        hp_reg       <= hp_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        red_cnt_reg  <= red_cnt_next;
        lvl_reg      <= lvl_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        da_reg       <= da_next;
        db_reg       <= db_next;
        prev_reg     <= prev_next;
        ua_reg       <= ua_next;
        res_reg      <= res_next;
    end

    tla_ram #(
        .WIDTH (NW),
        .DEPTH (NODES)
    ) u_depth_ram (
        .clk     (clk),
        .wr_en   (dep_wr_en),
        .wr_addr (dep_wr_addr),
        .wr_data (dep_wr_data),
        .rd_en   (dep_rd_en),
        .rd_addr (dep_rd_addr),
        .rd_data (dep_rd_data)
    );

    tla_ram #(
        .WIDTH (EW),
        .DEPTH (NODES * LEVELS)
    ) u_anc_ram (
        .clk     (clk),
        .wr_en   (anc_wr_en),
        .wr_addr (anc_wr_addr),
        .wr_data (anc_wr_data),
        .rd_en   (anc_rd_en),
        .rd_addr (anc_rd_addr),
        .rd_data (anc_rd_data)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign ancestor  = ancestor_reg;

endmodule

@@ rtl/tla_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
module tla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/tla_checker.sv @@
// Port-level checker of the ancestor query block and its bind to the top level.
`include "assert_macros.svh"

module tla_checker
    import tla_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_stall,
    input logic            out_valid,
    input logic            out_stall,
    input logic [IN_W-1:0] ancestor
);

    // Every request keeps the block busy after it is taken.
    `TLA_ASSERT_NEXT(a_busy_after_request, in_valid && !in_stall, in_stall ##1 in_stall, "block took a request too soon")

    // A result appears only right after the block was busy.
    `TLA_ASSERT_SAME(a_result_from_work, $rose(out_valid), $past(in_stall), "result appeared without work")

    // A stalled result holds its value.
    `TLA_ASSERT_NEXT(a_result_holds, out_valid && out_stall, out_valid && $stable(ancestor), "stalled result changed")

endmodule

bind tree_lca_binary_lifting_core tla_checker u_tla_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ancestor  (ancestor)
);
